@@ rtl/dbrc_pkg.sv @@
`timescale 1ns / 1ps

package dbrc_pkg;

    // protocol tags
    localparam logic [1:0] PROTO_PG    = 2'd0;
    localparam logic [1:0] PROTO_MYSQL = 2'd1;
    localparam logic [1:0] PROTO_REDIS = 2'd2;

    // query classes
    localparam logic [2:0] CLS_UNKNOWN   = 3'd0;
    localparam logic [2:0] CLS_READ      = 3'd1;
    localparam logic [2:0] CLS_WRITE     = 3'd2;
    localparam logic [2:0] CLS_TXN_BEGIN = 3'd3;
    localparam logic [2:0] CLS_TXN_END   = 3'd4;
    localparam logic [2:0] CLS_SESSION   = 3'd5;

    // framing characters
    localparam logic [7:0] CHAR_Q       = 8'h51;
    localparam logic [7:0] MYSQL_QUERY  = 8'h03;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CASE_MASK    = 8'hDF;

    // minimum message sizes
    localparam int SQL_MIN_BYTES   = 5;
    localparam int REDIS_MIN_BYTES = 3;

    // first eight keyword bytes, entry 0 is the first text byte
    typedef logic [7:0][7:0] t_kw_view;

    typedef struct packed {
        logic [2:0] query_class;
        logic       needs_sticky;
        logic       message_too_short;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // kw is right-justified, first character in the highest used byte
    function automatic logic kw_match(input t_kw_view buf_v, input logic [3:0] cnt,
                                      input logic [63:0] kw, input int len);
        logic hit;
        hit = (cnt >= 4'(len));
        for (int k = 0; k < 8; k++) begin
            if (k < len) begin
                if ((buf_v[k] & CASE_MASK) != kw[8*(len-1-k) +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    function automatic logic [2:0] classify_sql(input t_kw_view v, input logic [3:0] cnt);
        logic [2:0] cls;
        if (kw_match(v, cnt, 64'("BEGIN"), 5) || kw_match(v, cnt, 64'("START"), 5)) begin
            cls = CLS_TXN_BEGIN;
        end else if (kw_match(v, cnt, 64'("COMMIT"), 6) ||
                     kw_match(v, cnt, 64'("ROLLBACK"), 8)) begin
            cls = CLS_TXN_END;
        end else if (kw_match(v, cnt, 64'("SET"), 3)) begin
            cls = CLS_SESSION;
        end else if (kw_match(v, cnt, 64'("SELECT"), 6) ||
                     kw_match(v, cnt, 64'("SHOW"), 4)) begin
            cls = CLS_READ;
        end else if (kw_match(v, cnt, 64'("INSERT"), 6) ||
                     kw_match(v, cnt, 64'("UPDATE"), 6) ||
                     kw_match(v, cnt, 64'("DELETE"), 6)) begin
            cls = CLS_WRITE;
        end else begin
            cls = CLS_UNKNOWN;
        end
        return cls;
    endfunction

    function automatic logic [2:0] classify_redis(input t_kw_view v, input logic [3:0] cnt,
                                                  input logic framed, input logic [1:0] nl);
        logic [2:0] cls;
        if (!framed || nl < 2'd2 || cnt < 4'd3) begin
            cls = CLS_READ;
        end else if (kw_match(v, cnt, 64'("SET"), 3)) begin
            cls = CLS_WRITE;
        end else if (kw_match(v, cnt, 64'("GET"), 3)) begin
            cls = CLS_READ;
        end else if (cnt >= 4'd4 && (v[0] & CASE_MASK) == 8'h4D &&
                     (v[3] & CASE_MASK) == 8'h54) begin
            cls = CLS_TXN_BEGIN;
        end else if (kw_match(v, cnt, 64'("EXEC"), 4)) begin
            cls = CLS_TXN_END;
        end else begin
            cls = CLS_READ;
        end
        return cls;
    endfunction

endpackage

@@ rtl/dbrc_parse.sv @@
`timescale 1ns / 1ps

module dbrc_parse #(
    parameter int KEYWORD_WINDOW = 8,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_of_message,
    input  logic              i_last_of_message,
    input  logic [1:0]        i_protocol_kind,
    output dbrc_pkg::t_result o_result
);
    import dbrc_pkg::*;

    localparam int KWC_W  = $clog2(KEYWORD_WINDOW + 1);
    localparam int KIDX_W = $clog2(KEYWORD_WINDOW);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_byte_count, n_byte_count, c_byte_count;
    logic [31:0]            r_dlen, n_dlen, c_dlen;
    logic [7:0]             r_kind, n_kind, c_kind;
    logic [1:0]             r_proto, n_proto;
    logic                   r_in_text, n_in_text, c_in_text;
    logic [KWC_W-1:0]       r_kw_count, n_kw_count, c_kw_count;
    logic [1:0]             r_nl_count, n_nl_count, c_nl_count;
    logic                   r_cmd_end, n_cmd_end, c_cmd_end;
    logic                   r_star, n_star, c_star;
    logic [7:0]             r_kw_buf [KEYWORD_WINDOW];

    logic                   start;
    logic                   text_en;
    logic                   store_en;
    logic [32:0]            idx_x;
    logic [32:0]            cnt_x;
    t_kw_view               view;
    logic [3:0]             view_cnt;
    t_result                res;

    always_comb begin
        start        = i_first_of_message || (r_byte_count == '0);
        c_byte_count = start ? '0 : r_byte_count;
        c_dlen       = start ? '0 : r_dlen;
        c_kind       = start ? '0 : r_kind;
        c_in_text    = start ? 1'b0 : r_in_text;
        c_kw_count   = start ? '0 : r_kw_count;
        c_nl_count   = start ? '0 : r_nl_count;
        c_cmd_end    = start ? 1'b0 : r_cmd_end;
        c_star       = start ? 1'b0 : r_star;
        n_proto      = start ? i_protocol_kind : r_proto;

        n_byte_count = (c_byte_count == COUNT_MAX) ? c_byte_count : c_byte_count + 1'b1;
        idx_x        = 33'(c_byte_count);
        n_dlen       = c_dlen;
        n_kind       = c_kind;
        n_in_text    = c_in_text;
        n_nl_count   = c_nl_count;
        n_cmd_end    = c_cmd_end;
        n_star       = c_star;
        text_en      = 1'b0;
        store_en     = 1'b0;

        case (n_proto)
            PROTO_PG: begin
                if (idx_x == 33'd0) begin
                    n_kind = i_data_byte;
                end else if (idx_x <= 33'd4) begin
                    n_dlen = {c_dlen[23:0], i_data_byte};
                end else if (idx_x <= 33'(c_dlen)) begin
                    text_en = 1'b1;
                end
            end
            PROTO_MYSQL: begin
                if (idx_x < 33'd3) begin
                    n_dlen[8*c_byte_count[1:0] +: 8] = i_data_byte;
                end else if (idx_x == 33'd4) begin
                    n_kind = i_data_byte;
                end else if (idx_x >= 33'd5 && idx_x < 33'(c_dlen) + 33'd4) begin
                    text_en = 1'b1;
                end
            end
            PROTO_REDIS: begin
                if (idx_x == 33'd0) begin
                    n_star = (i_data_byte == CHAR_STAR);
                end else if (c_star) begin
                    if (c_nl_count < 2'd2) begin
                        if (i_data_byte == CHAR_LF) begin
                            n_nl_count = c_nl_count + 2'd1;
                        end
                    end else if (!c_cmd_end) begin
                        if (i_data_byte == CHAR_CR) begin
                            n_cmd_end = 1'b1;
                        end else begin
                            store_en = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // leading whitespace is dropped until the first text byte
        if (text_en && (c_in_text || !is_ws(i_data_byte))) begin
            n_in_text = 1'b1;
            store_en  = 1'b1;
        end
        if (c_kw_count >= KWC_W'(KEYWORD_WINDOW)) begin
            store_en = 1'b0;
        end
        n_kw_count = store_en ? c_kw_count + 1'b1 : c_kw_count;

        for (int k = 0; k < 8; k++) begin
            view[k] = (store_en && c_kw_count == KWC_W'(k)) ? i_data_byte : r_kw_buf[k];
        end
        view_cnt = (n_kw_count >= KWC_W'(8)) ? 4'd8 : 4'(n_kw_count);

        cnt_x = 33'(n_byte_count);
        res   = '0;
        case (n_proto)
            PROTO_PG, PROTO_MYSQL: begin
                if (cnt_x < 33'(SQL_MIN_BYTES)) begin
                    res.message_too_short = 1'b1;
                end else if (n_proto == PROTO_PG) begin
                    if (n_kind == CHAR_Q && cnt_x >= 33'(n_dlen) + 33'd1) begin
                        res.query_class = classify_sql(view, view_cnt);
                    end
                end else begin
                    if (n_kind == MYSQL_QUERY && cnt_x >= 33'(n_dlen) + 33'd4) begin
                        res.query_class = classify_sql(view, view_cnt);
                    end
                end
                res.needs_sticky = (res.query_class == CLS_TXN_BEGIN) ||
                                   (res.query_class == CLS_SESSION);
            end
            PROTO_REDIS: begin
                if (cnt_x < 33'(REDIS_MIN_BYTES)) begin
                    res.message_too_short = 1'b1;
                end else begin
                    res.query_class  = classify_redis(view, view_cnt, n_star, n_nl_count);
                    res.needs_sticky = (res.query_class == CLS_TXN_BEGIN);
                end
            end
            default: begin
            end
        endcase
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_dlen       <= '0;
            r_kind       <= '0;
            r_proto      <= PROTO_PG;
            r_in_text    <= 1'b0;
            r_kw_count   <= '0;
            r_nl_count   <= '0;
            r_cmd_end    <= 1'b0;
            r_star       <= 1'b0;
        end else if (i_step) begin
            // a zero count makes the next byte open a fresh message
            r_byte_count <= i_last_of_message ? '0 : n_byte_count;
            r_dlen       <= n_dlen;
            r_kind       <= n_kind;
            r_proto      <= n_proto;
            r_in_text    <= n_in_text;
            r_kw_count   <= n_kw_count;
            r_nl_count   <= n_nl_count;
            r_cmd_end    <= n_cmd_end;
            r_star       <= n_star;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && store_en) begin
            r_kw_buf[c_kw_count[KIDX_W-1:0]] <= i_data_byte;
        end
    end

endmodule

@@ rtl/db_request_classifier.sv @@
`timescale 1ns / 1ps
// input reg feeds result reg through dbrc_parse, where the parse state loop closes
// throughput: one byte per cycle unless a last byte meets a full, stalled result reg
// a message ending in a last byte yields one item, shown while the next one streams in
// reset: synchronous active-low i_rst_n clears handshake and parse state; no clearing pass
// keyword buffer entries are not reset, they are only read once written

module db_request_classifier #(
    parameter int KEYWORD_WINDOW = 8,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_message,
    input  logic       i_last_of_message,
    input  logic [1:0] i_protocol_kind,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_query_class,
    output logic       o_needs_sticky,
    output logic       o_message_too_short
);
    import dbrc_pkg::*;

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_first;
    logic       r_in_last;
    logic [1:0] r_in_proto;

    // result register stage
    logic       r_out_valid;
    t_result    r_out;

    t_result    parse_res;
    logic       advance;

    // a byte leaves the input register unless it is a last byte facing a full,
    // stalled result register; only last bytes produce an item
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_of_message;
            r_in_last  <= i_last_of_message;
            r_in_proto <= i_protocol_kind;
        end
    end

    // byte parser: header decode, keyword capture, classification
    dbrc_parse #(
        .KEYWORD_WINDOW (KEYWORD_WINDOW),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_parse (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (advance),
        .i_data_byte        (r_in_data),
        .i_first_of_message (r_in_first),
        .i_last_of_message  (r_in_last),
        .i_protocol_kind    (r_in_proto),
        .o_result           (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= parse_res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_query_class       = r_out.query_class;
    assign o_needs_sticky      = r_out.needs_sticky;
    assign o_message_too_short = r_out.message_too_short;

endmodule

@@ rtl/dbrc_checker.sv @@
`timescale 1ns / 1ps

module dbrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_query_class,
    input logic       o_needs_sticky,
    input logic       o_message_too_short
);
    import dbrc_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_query_class) &&
        $stable(o_needs_sticky) && $stable(o_message_too_short))
        else $error("result item changed while stalled");

    a_short_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_message_too_short |-> o_query_class == CLS_UNKNOWN && !o_needs_sticky)
        else $error("too-short item carries a class");

    a_sticky_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_needs_sticky |-> o_query_class == CLS_TXN_BEGIN ||
        o_query_class == CLS_SESSION)
        else $error("sticky flag on a non-pinning class");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_query_class <= CLS_SESSION)
        else $error("class code out of range");

endmodule

bind db_request_classifier dbrc_checker u_dbrc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_query_class       (o_query_class),
    .o_needs_sticky      (o_needs_sticky),
    .o_message_too_short (o_message_too_short)
);

@@ bench/dbrc_class_checker.sv @@
`timescale 1ns / 1ps

module dbrc_class_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel, observed
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_message,
    input  logic       i_last_of_message,
    input  logic [1:0] i_protocol_kind,
    // result channel, observed
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_query_class,
    input  logic       i_needs_sticky,
    input  logic       i_message_too_short,
    output int         o_error_count,
    output int         o_pending
);
    import dbrc_pkg::*;

    localparam int KW_DEPTH = 8;

    // parser state of the predictor
    logic [31:0] byte_idx;
    logic [31:0] decl_len;
    logic [7:0]  type_byte;
    logic [1:0]  proto;
    logic        text_started;
    logic [7:0]  kw_buf [KW_DEPTH];
    logic [3:0]  kw_len;
    logic [1:0]  lf_count;
    logic        cmd_done;
    logic        array_framed;

    t_result     class_queue [$];
    int          mismatch_count = 0;

    assign o_error_count = mismatch_count;

    function automatic void clear_parse();
        byte_idx     = '0;
        decl_len     = '0;
        type_byte    = '0;
        text_started = 1'b0;
        foreach (kw_buf[k]) kw_buf[k] = '0;
        kw_len       = '0;
        lf_count     = '0;
        cmd_done     = 1'b0;
        array_framed = 1'b0;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void keep_byte(input logic [7:0] b);
        if (kw_len < KW_DEPTH) begin
            kw_buf[kw_len[2:0]] = b;
            kw_len++;
        end
    endfunction

    // leading whitespace is dropped, the first KW_DEPTH bytes after it are kept
    function automatic void text_byte(input logic [7:0] b);
        if (!text_started) begin
            if (is_space(b)) return;
            text_started = 1'b1;
        end
        keep_byte(b);
    endfunction

    // case-insensitive match of the whole word at the start of the kept text
    function automatic logic lead_word(input string w);
        logic hit;
        hit = (kw_len >= w.len()) && (w.len() <= KW_DEPTH);
        for (int k = 0; k < w.len(); k++) begin
            if (k < kw_len && (kw_buf[k] & CASE_MASK) != w[k]) hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic logic [2:0] sql_class();
        if (lead_word("BEGIN") || lead_word("START")) return CLS_TXN_BEGIN;
        if (lead_word("COMMIT") || lead_word("ROLLBACK")) return CLS_TXN_END;
        if (lead_word("SET")) return CLS_SESSION;
        if (lead_word("SELECT") || lead_word("SHOW")) return CLS_READ;
        if (lead_word("INSERT") || lead_word("UPDATE") || lead_word("DELETE")) return CLS_WRITE;
        return CLS_UNKNOWN;
    endfunction

    function automatic logic [2:0] redis_class();
        if (!array_framed || lf_count < 2 || kw_len < 3) return CLS_READ;
        if (lead_word("SET")) return CLS_WRITE;
        if (lead_word("GET")) return CLS_READ;
        // any four-plus letter command shaped m..t opens a transaction
        if (kw_len >= 4 && (kw_buf[0] & CASE_MASK) == "M" && (kw_buf[3] & CASE_MASK) == "T")
            return CLS_TXN_BEGIN;
        if (lead_word("EXEC")) return CLS_TXN_END;
        return CLS_READ;
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [1:0] kind);
        logic [31:0] idx;
        t_result     res;
        if (first || byte_idx == 0) begin
            clear_parse();
            proto = kind;
        end
        idx = byte_idx;
        if (byte_idx != '1) byte_idx++;

        case (proto)
            PROTO_PG: begin
                if (idx == 0) begin
                    type_byte = b;
                end else if (idx <= 4) begin
                    decl_len = {decl_len[23:0], b};
                end else if (idx <= decl_len) begin
                    text_byte(b);
                end
            end
            PROTO_MYSQL: begin
                if (idx < 3) begin
                    decl_len = decl_len | (32'(b) << (8 * idx));
                end else if (idx == 4) begin
                    type_byte = b;
                end else if (idx >= 5 && {1'b0, idx} < {1'b0, decl_len} + 33'd4) begin
                    text_byte(b);
                end
            end
            PROTO_REDIS: begin
                if (idx == 0) begin
                    array_framed = (b == CHAR_STAR);
                end else if (array_framed) begin
                    if (lf_count < 2) begin
                        if (b == CHAR_LF) lf_count++;
                    end else if (!cmd_done) begin
                        if (b == CHAR_CR) cmd_done = 1'b1;
                        else keep_byte(b);
                    end
                end
            end
            default: ;
        endcase

        if (last) begin
            res = '0;
            if (proto == PROTO_PG || proto == PROTO_MYSQL) begin
                if (byte_idx < SQL_MIN_BYTES) begin
                    res.message_too_short = 1'b1;
                end else if (proto == PROTO_PG) begin
                    if (type_byte == CHAR_Q && {1'b0, byte_idx} >= {1'b0, decl_len} + 33'd1)
                        res.query_class = sql_class();
                end else begin
                    if (type_byte == MYSQL_QUERY &&
                        {1'b0, byte_idx} >= {1'b0, decl_len} + 33'd4)
                        res.query_class = sql_class();
                end
                res.needs_sticky = (res.query_class == CLS_TXN_BEGIN) ||
                                   (res.query_class == CLS_SESSION);
            end else if (proto == PROTO_REDIS) begin
                if (byte_idx < REDIS_MIN_BYTES) begin
                    res.message_too_short = 1'b1;
                end else begin
                    res.query_class  = redis_class();
                    res.needs_sticky = (res.query_class == CLS_TXN_BEGIN);
                end
            end
            class_queue.push_back(res);
            clear_parse();
        end
    endtask

    task automatic check_result();
        t_result want;
        if (class_queue.size() == 0) begin
            $error("unexpected result item: query_class %0d, needs_sticky %0d, too_short %0d",
                   i_query_class, i_needs_sticky, i_message_too_short);
            mismatch_count++;
        end else begin
            want = class_queue.pop_front();
            if (i_query_class !== want.query_class) begin
                $error("query_class: expected %0d, actual %0d", want.query_class, i_query_class);
                mismatch_count++;
            end
            if (i_needs_sticky !== want.needs_sticky) begin
                $error("needs_sticky: expected %0d, actual %0d", want.needs_sticky,
                       i_needs_sticky);
                mismatch_count++;
            end
            if (i_message_too_short !== want.message_too_short) begin
                $error("message_too_short: expected %0d, actual %0d", want.message_too_short,
                       i_message_too_short);
                mismatch_count++;
            end
        end
    endtask

    // results are popped before the byte of the same edge is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            proto = PROTO_PG;
            class_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                take_byte(i_data_byte, i_first_of_message, i_last_of_message, i_protocol_kind);
            end
        end
        o_pending <= class_queue.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import dbrc_pkg::*;

    // protocol tag with no parser behind it
    localparam logic [1:0] PROTO_NONE = 2'd3;

    localparam int ITEM_TARGET  = 1550;
    localparam int CYCLE_LIMIT  = 600000;
    // settling margin; a result passes the input and result registers after its last byte
    localparam int DRAIN_CYCLES = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = '0;
    logic       i_first_of_message = 1'b0;
    logic       i_last_of_message = 1'b0;
    logic [1:0] i_protocol_kind = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [2:0] o_query_class;
    logic       o_needs_sticky;
    logic       o_message_too_short;

    int         error_count;
    int         results_pending;
    int         bytes_accepted = 0;
    int         cycle_count = 0;

    // message under construction, one entry per byte
    logic [7:0] msg_bytes [$];

    logic [7:0] space_chars [6] = '{8'h20, 8'h09, CHAR_LF, 8'h0B, 8'h0C, CHAR_CR};

    // real keywords, near misses and words that are no keyword at all
    string sql_words [16] = '{"BEGIN", "START", "COMMIT", "ROLLBACK", "SET", "SELECT",
                              "SHOW", "INSERT", "UPDATE", "DELETE", "SE", "SELEC",
                              "EXPLAIN", "ROLLBAC", "SHO", "VACUUM"};
    string redis_words [10] = '{"SET", "GET", "MULTI", "EXEC", "MSET", "DEL", "GE",
                                "SUBSCRIBE", "INCR", "EXE"};

    db_request_classifier i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_first_of_message  (i_first_of_message),
        .i_last_of_message   (i_last_of_message),
        .i_protocol_kind     (i_protocol_kind),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_query_class       (o_query_class),
        .o_needs_sticky      (o_needs_sticky),
        .o_message_too_short (o_message_too_short)
    );

    // watches both channels, predicts every result and compares it
    dbrc_class_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_ready          (o_ready),
        .i_data_byte         (i_data_byte),
        .i_first_of_message  (i_first_of_message),
        .i_last_of_message   (i_last_of_message),
        .i_protocol_kind     (i_protocol_kind),
        .i_out_valid         (o_valid),
        .i_out_ready         (i_ready),
        .i_query_class       (o_query_class),
        .i_needs_sticky      (o_needs_sticky),
        .i_message_too_short (o_message_too_short),
        .o_error_count       (error_count),
        .o_pending           (results_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs or drops a result
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // declared length: usually exact, sometimes undersized, short, long or garbage
    function automatic logic [31:0] pick_len(input int exact);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return exact;
        if (r < 80) return $urandom_range(0, 4);
        if (r < 88) return (exact > 5) ? $urandom_range(5, exact - 1) : exact;
        if (r < 95) return exact + $urandom_range(1, 3);
        return $urandom();
    endfunction

    // result side stalls: random low stretches, sometimes a long ready stretch
    initial begin : result_stalls
        int low_len;
        int high_len;
        forever begin
            low_len  = pick_gap();
            high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 8);
            if (low_len > 0) begin
                i_ready <= 1'b0;
                repeat (low_len) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat (high_len) @(posedge i_clk);
        end
    end

    // append text, letters flipped to lower case at random when mix_case is set
    task automatic add_str(input string s, input bit mix_case);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if (mix_case && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A &&
                $urandom_range(0, 2) == 0) begin
                c = c ^ 8'h20;
            end
            msg_bytes.push_back(c);
        end
    endtask

    task automatic add_crlf();
        msg_bytes.push_back(CHAR_CR);
        msg_bytes.push_back(CHAR_LF);
    endtask

    // query text: whitespace run, maybe a stray byte, usually a word, then a random tail
    task automatic add_sql_text();
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        repeat (n) msg_bytes.push_back(space_chars[$urandom_range(0, 5)]);
        if ($urandom_range(0, 15) == 0) msg_bytes.push_back(8'($urandom()));
        if ($urandom_range(0, 19) != 0) add_str(sql_words[$urandom_range(0, 15)], 1'b1);
        if ($urandom_range(0, 1) == 1) msg_bytes.push_back(8'h20);
        n = $urandom_range(0, 6);
        repeat (n) begin
            msg_bytes.push_back(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h21, 8'h7E))
                                                              : 8'($urandom()));
        end
        // trailing nul as a real client would send
        if ($urandom_range(0, 1) == 1) msg_bytes.push_back(8'h00);
    endtask

    // postgres: type byte, 32-bit big-endian length, text
    task automatic build_pg_query();
        logic [31:0] len;
        msg_bytes.delete();
        msg_bytes.push_back(($urandom_range(0, 9) != 0) ? CHAR_Q : 8'($urandom()));
        repeat (4) msg_bytes.push_back(8'h00);
        add_sql_text();
        len = pick_len(msg_bytes.size() - 1);
        msg_bytes[1] = len[31:24];
        msg_bytes[2] = len[23:16];
        msg_bytes[3] = len[15:8];
        msg_bytes[4] = len[7:0];
    endtask

    // mysql: 24-bit little-endian length, sequence id, command byte, text
    task automatic build_mysql_query();
        logic [31:0] len;
        msg_bytes.delete();
        repeat (3) msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'($urandom()));
        msg_bytes.push_back(($urandom_range(0, 9) != 0) ? MYSQL_QUERY : 8'($urandom()));
        add_sql_text();
        len = pick_len(msg_bytes.size() - 4);
        msg_bytes[0] = len[7:0];
        msg_bytes[1] = len[15:8];
        msg_bytes[2] = len[23:16];
    endtask

    // redis array: *n, $len, command line, maybe an argument
    task automatic build_redis_command();
        int n;
        msg_bytes.delete();
        msg_bytes.push_back(($urandom_range(0, 9) != 0) ? CHAR_STAR : 8'($urandom()));
        add_str("2", 1'b0);
        add_crlf();
        // sometimes the bulk length line is missing, so no second line feed before the command
        if ($urandom_range(0, 9) != 0) begin
            add_str("$3", 1'b0);
            add_crlf();
        end
        add_str(redis_words[$urandom_range(0, 9)], 1'b1);
        if ($urandom_range(0, 6) != 0) begin
            add_crlf();
            add_str("$3", 1'b0);
            add_crlf();
            add_str("key", 1'b0);
            add_crlf();
        end else begin
            // command runs on without a carriage return
            n = $urandom_range(0, 6);
            repeat (n) msg_bytes.push_back(8'($urandom()));
        end
    endtask

    task automatic build_noise();
        int n;
        msg_bytes.delete();
        n = $urandom_range(1, 12);
        repeat (n) msg_bytes.push_back(8'($urandom()));
    endtask

    // one item; valid stays up with the payload held until the handshake
    task automatic push_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [1:0] kind);
        i_valid            <= 1'b1;
        i_data_byte        <= b;
        i_first_of_message <= first;
        i_last_of_message  <= last;
        i_protocol_kind    <= kind;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_accepted++;
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // restart_at puts an extra first mark mid-message; the tag is random elsewhere
    task automatic send_message(input logic [1:0] kind, input bit mark_first,
                                input bit mark_last, input int restart_at, input bit steady);
        for (int i = 0; i < msg_bytes.size(); i++) begin
            if (!steady) idle_sender(pick_gap());
            push_byte(msg_bytes[i], (i == 0 && mark_first) || i == restart_at,
                      mark_last && i == msg_bytes.size() - 1,
                      (i == 0 || i == restart_at) ? kind : 2'($urandom_range(0, 3)));
        end
    endtask

    // hold the sender off until every predicted result has come out
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int         pick;
        int         msg_count;
        int         restart_at;
        logic [1:0] kind;
        bit         mark_first;
        bit         mark_last;

        msg_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone all-ones byte: sql message under the minimum size
        msg_bytes = '{8'hFF};
        send_message(PROTO_PG, 1'b1, 1'b1, -1, 1'b1);
        // all-zero byte on the tag that has no parser
        msg_bytes = '{8'h00};
        send_message(PROTO_NONE, 1'b1, 1'b1, -1, 1'b1);
        // no first mark after a last byte still opens a message; whitespace before set
        msg_bytes = '{CHAR_Q, 8'h00, 8'h00, 8'h00, 8'h08};
        add_str(" sEt", 1'b0);
        send_message(PROTO_PG, 1'b0, 1'b1, -1, 1'b0);
        // redis command shaped m..t
        msg_bytes = '{CHAR_STAR, CHAR_LF, CHAR_LF};
        add_str("muLt", 1'b0);
        send_message(PROTO_REDIS, 1'b1, 1'b1, -1, 1'b0);
        // mysql header cut short
        msg_bytes = '{8'h00, 8'h00, 8'h00};
        send_message(PROTO_MYSQL, 1'b1, 1'b1, -1, 1'b0);
        wait_results_drained();

        // random traffic, mostly well formed messages with random content
        while (bytes_accepted < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                build_pg_query();
                kind = PROTO_PG;
            end else if (pick < 55) begin
                build_mysql_query();
                kind = PROTO_MYSQL;
            end else if (pick < 82) begin
                build_redis_command();
                kind = PROTO_REDIS;
            end else begin
                build_noise();
                kind = 2'($urandom_range(0, 3));
            end
            // truncated messages hit the size floors and the length checks
            if ($urandom_range(0, 15) == 0) begin
                pick = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > pick) void'(msg_bytes.pop_back());
            end
            mark_first = ($urandom_range(0, 9) != 0);
            mark_last  = ($urandom_range(0, 29) != 0);
            restart_at = ($urandom_range(0, 14) == 0) ? $urandom_range(1, msg_bytes.size()) : -1;
            send_message(kind, mark_first, mark_last, restart_at, $urandom_range(0, 6) == 0);
            msg_count++;
            if (msg_count % 25 == 0) wait_results_drained();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/dbrc_pkg.sv
rtl/dbrc_parse.sv
rtl/db_request_classifier.sv
rtl/dbrc_checker.sv
bench/dbrc_class_checker.sv
bench/tb.sv
